// ===== hw/rtl/etc_pkg.sv =====
// Shared types, widths, register indexes and reset values for the edge triggered capture block.
package etc_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int COUNT_BITS    = 16;
  localparam int GAIN_BITS     = 8;
  localparam int OUT_BITS      = SAMPLE_BITS + GAIN_BITS;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [OUT_BITS-1:0]    scaled_t;
  typedef logic        [COUNT_BITS-1:0]  count_t;
  typedef logic        [GAIN_BITS-1:0]   gain_t;
  typedef logic        [CFG_IDX_BITS-1:0]  cfg_idx_t;
  typedef logic        [CFG_DATA_BITS-1:0] cfg_data_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_TRIG_LEVEL  = 3'd0,
    REG_TRIG_SOURCE = 3'd1,
    REG_GAIN_CH1    = 3'd2,
    REG_GAIN_CH2    = 3'd3,
    REG_CAPTURE_LEN = 3'd4
  } cfg_reg_e;

  // Register reset values.
  localparam sample_t RST_TRIG_LEVEL  = '0;
  localparam logic    RST_TRIG_SOURCE = 1'b0;
  localparam gain_t   RST_GAIN        = gain_t'(10);
  localparam count_t  RST_CAPTURE_LEN = count_t'(96);

endpackage

// ===== hw/rtl/etc_in_if.sv =====
// Input channel carrying one two-channel sample pair per word.
interface etc_in_if;
  import etc_pkg::*;

  logic    valid;
  logic    ready;
  sample_t ch1_sample;
  sample_t ch2_sample;

  modport source (output valid, output ch1_sample, output ch2_sample, input ready);
  modport sink   (input valid, input ch1_sample, input ch2_sample, output ready);
endinterface

// ===== hw/rtl/etc_out_if.sv =====
// Output channel carrying one scaled, indexed sample pair per word.
interface etc_out_if;
  import etc_pkg::*;

  logic    valid;
  logic    ready;
  scaled_t scaled_ch1;
  scaled_t scaled_ch2;
  count_t  sample_index;
  logic    capture_last;

  modport source (output valid, output scaled_ch1, output scaled_ch2,
                  output sample_index, output capture_last, input ready);
  modport sink   (input valid, input scaled_ch1, input scaled_ch2,
                  input sample_index, input capture_last, output ready);
endinterface

// ===== hw/rtl/edge_triggered_capture.sv =====
// Rising-edge trigger with gain scaling and capture windowing for a two-channel stream.
// An accepted word is held in the input register, and its result then in the result register that drives res_o.
// Throughput: one sample pair per cycle; the input register and the result register
// each advance every cycle while the output side keeps up.
// Reset clears the trigger state, empties both registers and loads the register defaults
// (level 0, source channel one, gains 10, capture length 96).
module edge_triggered_capture (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  etc_pkg::cfg_idx_t  cfg_idx_i,
  input  etc_pkg::cfg_data_t cfg_wdata_i,
  etc_in_if.sink             smp_i,
  etc_out_if.source          res_o
);
  import etc_pkg::*;

  // Configuration registers.
  sample_t trig_level_q;
  logic    trig_source_q;
  gain_t   gain_ch1_q;
  gain_t   gain_ch2_q;
  count_t  capture_len_q;

  // Trigger state.
  logic   armed_q, armed_d;
  logic   triggered_q, triggered_d;
  count_t cnt_q, cnt_d;

  // Input register.
  logic    in_vld_q;
  sample_t ch1_q, ch2_q;

  // Result register.
  logic    out_vld_q;
  scaled_t scaled_ch1_q, scaled_ch2_q;
  count_t  index_q;
  logic    last_q;

  logic    cfg_abort;
  sample_t trig_val;
  logic    below;
  logic    trig_now;
  count_t  cnt_eff;
  logic    emit;
  logic    last;
  logic    out_free;
  logic    adv;
  logic [COUNT_BITS:0] cnt_inc;
  scaled_t prod1, prod2;

  // Writes to the trigger level, gain and capture length registers abort a running capture.
  always_comb begin
    cfg_abort = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TRIG_LEVEL:  cfg_abort = 1'b1;
        REG_GAIN_CH1:    cfg_abort = 1'b1;
        REG_GAIN_CH2:    cfg_abort = 1'b1;
        REG_CAPTURE_LEN: cfg_abort = 1'b1;
        default:         cfg_abort = 1'b0;
      endcase
    end
  end

  // Configuration register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_level_q  <= RST_TRIG_LEVEL;
      trig_source_q <= RST_TRIG_SOURCE;
      gain_ch1_q    <= RST_GAIN;
      gain_ch2_q    <= RST_GAIN;
      capture_len_q <= RST_CAPTURE_LEN;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TRIG_LEVEL:  trig_level_q  <= sample_t'(cfg_wdata_i[SAMPLE_BITS-1:0]);
        REG_TRIG_SOURCE: trig_source_q <= cfg_wdata_i[0];
        REG_GAIN_CH1:    gain_ch1_q    <= cfg_wdata_i[GAIN_BITS-1:0];
        REG_GAIN_CH2:    gain_ch2_q    <= cfg_wdata_i[GAIN_BITS-1:0];
        REG_CAPTURE_LEN: capture_len_q <= cfg_wdata_i[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Trigger decision for the word in the input register.
  always_comb begin
    trig_val = trig_source_q ? ch2_q : ch1_q;
    below    = (trig_val <= trig_level_q);
    trig_now = triggered_q || (armed_q && !below);
    cnt_eff  = triggered_q ? cnt_q : '0;
    emit     = trig_now && (cnt_eff < capture_len_q);
    cnt_inc  = {1'b0, cnt_eff} + (COUNT_BITS+1)'(1);
    last     = (cnt_inc == {1'b0, capture_len_q});
  end

  // Handshake: the input register moves on when its word needs no slot or one is free.
  assign out_free    = !out_vld_q || res_o.ready;
  assign adv         = in_vld_q && (!emit || out_free);
  assign smp_i.ready = !in_vld_q || adv;

  // Next trigger state for an advancing word.
  always_comb begin
    armed_d     = armed_q;
    triggered_d = triggered_q;
    cnt_d       = cnt_q;
    if (adv) begin
      if (!triggered_q && below) begin
        armed_d = 1'b1;
      end else if (!triggered_q && armed_q) begin
        armed_d = 1'b0;
      end
      triggered_d = emit && !last;
      cnt_d       = (emit && !last) ? cnt_inc[COUNT_BITS-1:0] : '0;
    end
  end

  // Trigger state registers; a configuration abort takes precedence.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q     <= 1'b0;
      triggered_q <= 1'b0;
      cnt_q       <= '0;
    end else if (cfg_abort) begin
      triggered_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      armed_q     <= armed_d;
      triggered_q <= triggered_d;
      cnt_q       <= cnt_d;
    end
  end

  // Input register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (smp_i.ready) begin
      in_vld_q <= smp_i.valid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (smp_i.valid && smp_i.ready) begin
      ch1_q <= smp_i.ch1_sample;
      ch2_q <= smp_i.ch2_sample;
    end
  end

  // Gain scaling: signed sample times unsigned gain, exact in the output width.
  always_comb begin
    prod1 = scaled_t'(ch1_q) * scaled_t'({1'b0, gain_ch1_q});
    prod2 = scaled_t'(ch2_q) * scaled_t'({1'b0, gain_ch2_q});
  end

  // Result register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv && emit) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      scaled_ch1_q <= prod1;
      scaled_ch2_q <= prod2;
      index_q      <= cnt_eff;
      last_q       <= last;
    end
  end

  assign res_o.valid        = out_vld_q;
  assign res_o.scaled_ch1   = scaled_ch1_q;
  assign res_o.scaled_ch2   = scaled_ch2_q;
  assign res_o.sample_index = index_q;
  assign res_o.capture_last = last_q;

  // Firing always clears the arm flag, so both are never set together.
  assert property (@(posedge clk_i) disable iff (!rst_ni) triggered_q |-> !armed_q)
    else $error("armed and triggered set together");

  // The sample counter only runs during a capture.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !triggered_q |-> (cnt_q == '0))
    else $error("sample counter nonzero outside a capture");

  // The final word of a capture ends the capture.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (adv && emit && last) |=> !triggered_q)
    else $error("capture still running after its last word");

  // An emitted word always lands in the result register.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (adv && emit) |=> res_o.valid)
    else $error("emitted word missing from result register");

endmodule
